// File: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the sof/eof frame checker
// Byte and checksum widths, register indexes and reset values, and the
// control group that steers the running payload sum.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int ByteW   = 8;
  localparam int SumW    = 16;
  localparam int CfgIdxW = 2;

  // default framing geometry
  localparam int FrameLen     = 104;
  localparam int PayloadFirst = 1;
  localparam int PayloadLen   = 95;
  localparam int SumPos       = 96;
  localparam int EndPos       = 98;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgStartValue = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgEndValue   = CfgIdxW'(1);

  localparam logic [ByteW-1:0] StartValueRst = ByteW'(170);
  localparam logic [ByteW-1:0] EndValueRst   = ByteW'(85);

  typedef struct packed {
    logic shift;   // window moves by one byte
    logic sub_ok;  // byte leaving the payload span was written
    logic add_ok;  // byte entering the payload span was written
  } sum_ctrl_t;

endpackage

// File: rtl/sfc_if.sv
// ----------------------------------------------------------------------------
// sfc_if: request channels of the sof/eof frame checker
// Valid/ready channels for received bytes and for tagged output bytes.
// ----------------------------------------------------------------------------
interface sfc_in_if;
  logic                      valid;
  logic                      ready;
  logic [sfc_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface sfc_out_if;
  logic                      valid;
  logic                      ready;
  logic [sfc_pkg::ByteW-1:0] out_byte;
  logic                      in_frame;
  logic                      frame_first;
  logic                      frame_last;

  modport source (output valid, output out_byte, output in_frame, output frame_first,
                  output frame_last, input ready);
  modport sink (input valid, input out_byte, input in_frame, input frame_first,
                input frame_last, output ready);
endinterface

// File: rtl/sfc_cell.sv
// ----------------------------------------------------------------------------
// sfc_cell: one byte of the receive window
// Takes the byte of its younger neighbour whenever the window shifts.
// ----------------------------------------------------------------------------
module sfc_cell (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic [sfc_pkg::ByteW-1:0] byte_i,
  output logic [sfc_pkg::ByteW-1:0] byte_o
);

  logic [sfc_pkg::ByteW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/sfc_sum.sv
// ----------------------------------------------------------------------------
// sfc_sum: running payload checksum
// 16-bit wrapping sum over the payload span, updated by one byte in and one
// byte out on every window shift.
// ----------------------------------------------------------------------------
module sfc_sum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sfc_pkg::sum_ctrl_t        ctrl_i,
  input  logic [sfc_pkg::ByteW-1:0] sub_byte_i,
  input  logic [sfc_pkg::ByteW-1:0] add_byte_i,
  output logic [sfc_pkg::SumW-1:0]  sum_o
);

  logic [sfc_pkg::SumW-1:0] sum_q, sum_d;
  logic [sfc_pkg::SumW-1:0] sub_ext, add_ext;

  assign sub_ext = ctrl_i.sub_ok ? sfc_pkg::SumW'(sub_byte_i) : '0;
  assign add_ext = ctrl_i.add_ok ? sfc_pkg::SumW'(add_byte_i) : '0;
  assign sum_d   = sum_q - sub_ext + add_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.shift) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// File: rtl/sof_eof_frame_checker_core.sv
// ----------------------------------------------------------------------------
// sof_eof_frame_checker_core: start/end marker framing with additive checksum
// A byte that completes the window is marked pending and tagged from the
// registered window once the output register is free; its result sits there.
// Throughput: one byte per cycle unless output stalls, set by single-step shifts.
// The first FRAME_LEN-1 bytes after reset only fill the window and give no result.
// Reset clears the fill count, checksum, frame count and output valid, and
// loads the start and end marker registers with their defaults.
// ----------------------------------------------------------------------------
module sof_eof_frame_checker_core #(
  parameter int FRAME_LEN     = sfc_pkg::FrameLen,
  parameter int PAYLOAD_FIRST = sfc_pkg::PayloadFirst,
  parameter int PAYLOAD_LEN   = sfc_pkg::PayloadLen,
  parameter int SUM_POS       = sfc_pkg::SumPos,
  parameter int END_POS       = sfc_pkg::EndPos
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfc_pkg::ByteW-1:0]   cfg_data_i,
  sfc_in_if.sink                      in_i,
  sfc_out_if.source                   out_o
);

  localparam int FillW = $clog2(FRAME_LEN + 1);
  localparam int RemW  = $clog2(FRAME_LEN);
  localparam int SumHi = (PAYLOAD_FIRST + PAYLOAD_LEN > FRAME_LEN) ?
                         FRAME_LEN : PAYLOAD_FIRST + PAYLOAD_LEN;

  logic [sfc_pkg::ByteW-1:0] start_q, end_q;
  logic [FillW-1:0]          fill_q, fill_d;
  logic [RemW-1:0]           rem_q, rem_d;
  logic                      pending_q, pending_d;
  logic                      in_acc, fire, match, full_after;

  logic                      out_valid_q, out_valid_d;
  logic [sfc_pkg::ByteW-1:0] out_byte_q;
  logic                      in_frame_q, first_q, last_q;
  logic                      in_frame_d, first_d, last_d;

  logic [sfc_pkg::ByteW-1:0] x [FRAME_LEN+1];
  logic [sfc_pkg::ByteW-1:0] end_byte, sum_lo, sum_hi, sub_byte, add_byte;
  logic [sfc_pkg::SumW-1:0]  sum;
  sfc_pkg::sum_ctrl_t        sum_ctrl;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= sfc_pkg::StartValueRst;
      end_q   <= sfc_pkg::EndValueRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfc_pkg::CfgStartValue: start_q <= cfg_data_i;
        sfc_pkg::CfgEndValue:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign fire        = pending_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !pending_q || fire;
  assign in_acc      = in_i.valid && in_i.ready;
  assign full_after  = fill_q >= FillW'(FRAME_LEN - 1);

  assign fill_d    = (in_acc && fill_q != FillW'(FRAME_LEN)) ? fill_q + FillW'(1) : fill_q;
  assign pending_d = in_acc ? full_after : (fire ? 1'b0 : pending_q);

  // cell chain, oldest byte in cell 0, x[FRAME_LEN] is the arriving byte
  assign x[FRAME_LEN] = in_i.in_byte;

  for (genvar k = 0; k < FRAME_LEN; k++) begin : g_cell
    sfc_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_acc),
      .byte_i  (x[k+1]),
      .byte_o  (x[k])
    );
  end

  // checksum span; unwritten cells are kept out of the sum
  if (PAYLOAD_FIRST < FRAME_LEN) begin : g_sum_on
    localparam int SubThr = FRAME_LEN - PAYLOAD_FIRST;
    localparam int AddThr = FRAME_LEN - SumHi;
    assign sum_ctrl.sub_ok = fill_q >= FillW'(SubThr);
    assign sum_ctrl.add_ok = fill_q >= FillW'(AddThr);
    assign sub_byte        = x[PAYLOAD_FIRST];
    assign add_byte        = x[SumHi];
  end else begin : g_sum_off
    assign sum_ctrl.sub_ok = 1'b0;
    assign sum_ctrl.add_ok = 1'b0;
    assign sub_byte        = '0;
    assign add_byte        = '0;
  end
  assign sum_ctrl.shift = in_acc;

  sfc_sum u_sum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sum_ctrl),
    .sub_byte_i (sub_byte),
    .add_byte_i (add_byte),
    .sum_o      (sum)
  );

  // marker and checksum taps, zero beyond the window
  if (END_POS < FRAME_LEN) begin : g_end_on
    assign end_byte = x[END_POS];
  end else begin : g_end_off
    assign end_byte = '0;
  end

  if (SUM_POS < FRAME_LEN) begin : g_lo_on
    assign sum_lo = x[SUM_POS];
  end else begin : g_lo_off
    assign sum_lo = '0;
  end

  if (SUM_POS + 1 < FRAME_LEN) begin : g_hi_on
    assign sum_hi = x[SUM_POS+1];
  end else begin : g_hi_off
    assign sum_hi = '0;
  end

  assign match = (x[0] == start_q) && (end_byte == end_q) && (sum == {sum_hi, sum_lo});

  // tagging of the oldest byte
  always_comb begin
    in_frame_d = 1'b0;
    first_d    = 1'b0;
    last_d     = 1'b0;
    rem_d      = rem_q;
    if (rem_q != '0) begin
      in_frame_d = 1'b1;
      last_d     = rem_q == RemW'(1);
      rem_d      = rem_q - RemW'(1);
    end else if (match) begin
      in_frame_d = 1'b1;
      first_d    = 1'b1;
      rem_d      = RemW'(FRAME_LEN - 1);
      last_d     = (FRAME_LEN == 1);
    end
  end

  assign out_valid_d = fire ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pending_q   <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        rem_q <= rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q <= x[0];
      in_frame_q <= in_frame_d;
      first_q    <= first_d;
      last_q     <= last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.in_frame    = in_frame_q;
  assign out_o.frame_first = first_q;
  assign out_o.frame_last  = last_q;

  // a result is only formed from a full window
  a_pending_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> fill_q == FillW'(FRAME_LEN))
    else $error("result pending on a partly filled window");

  // the window never shifts past a byte whose result is still owed
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && pending_q) |-> fire)
    else $error("window shifted over an untagged byte");

  // frame count steps down by one per tagged frame byte
  a_rem_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rem_q != '0) |=> rem_q == $past(rem_q) - RemW'(1))
    else $error("frame byte count out of step");

  // a validated start loads the count of frame bytes still to follow
  a_rem_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && rem_q == '0 && match) |=> rem_q == RemW'(FRAME_LEN - 1))
    else $error("frame count not loaded on start");

endmodule

// File: test/sfc_tag_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfc_tag_checker: byte tag prediction and comparison for the frame checker
// Follows every accepted byte through a private copy of the window, the
// marker registers and the frame countdown, queues the tag each byte should
// leave with, and compares the tagged bytes coming out of the core in order.
// ----------------------------------------------------------------------------
module sfc_tag_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sfc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sfc_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        run_over_i,
  sfc_in_if                           in_mon,
  sfc_out_if                          out_mon,
  output int                          fail_cnt_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [sfc_pkg::ByteW-1:0] out_byte;
    logic                      in_frame;
    logic                      frame_first;
    logic                      frame_last;
  } byte_tag_t;

  byte_tag_t                 tags_due_q[$];
  byte_tag_t                 seen;
  byte_tag_t                 due;
  logic [sfc_pkg::ByteW-1:0] start_val;
  logic [sfc_pkg::ByteW-1:0] end_val;
  logic [sfc_pkg::ByteW-1:0] win [sfc_pkg::FrameLen];
  logic [sfc_pkg::SumW-1:0]  pay_sum;
  int                        held;
  int                        frame_left;

  initial fail_cnt_o = 0;

  task automatic report_tag(input string what, input byte_tag_t got, input byte_tag_t want);
    $display("%0t tag check: %s: got byte %02h tags %b%b%b, want byte %02h tags %b%b%b",
             $realtime, what, got.out_byte, got.in_frame, got.frame_first, got.frame_last,
             want.out_byte, want.in_frame, want.frame_first, want.frame_last);
    fail_cnt_o++;
  endtask

  // offsets past the window read as zero
  function automatic logic [sfc_pkg::ByteW-1:0] byte_at(input int pos);
    return (pos < sfc_pkg::FrameLen) ? win[pos] : '0;
  endfunction

  function automatic void slide_window(input logic [sfc_pkg::ByteW-1:0] b);
    byte_tag_t                t;
    logic [sfc_pkg::SumW-1:0] word;
    if (held < sfc_pkg::FrameLen) begin
      win[held] = b;
      held++;
    end
    if (held < sfc_pkg::FrameLen) return;
    t = '0;
    t.out_byte = win[0];
    if (frame_left > 0) begin
      t.in_frame   = 1'b1;
      t.frame_last = (frame_left == 1);
      frame_left--;
    end else if (win[0] == start_val) begin
      pay_sum = '0;
      for (int k = 0; k < sfc_pkg::PayloadLen; k++) begin
        pay_sum += sfc_pkg::SumW'(byte_at(sfc_pkg::PayloadFirst + k));
      end
      word = {byte_at(sfc_pkg::SumPos + 1), byte_at(sfc_pkg::SumPos)};
      if (byte_at(sfc_pkg::EndPos) == end_val && pay_sum == word) begin
        t.in_frame    = 1'b1;
        t.frame_first = 1'b1;
        frame_left    = sfc_pkg::FrameLen - 1;
        t.frame_last  = (frame_left == 0);
      end
    end
    for (int k = 0; k < sfc_pkg::FrameLen - 1; k++) win[k] = win[k + 1];
    held = sfc_pkg::FrameLen - 1;
    tags_due_q.push_back(t);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_val  = sfc_pkg::StartValueRst;
      end_val    = sfc_pkg::EndValueRst;
      held       = 0;
      frame_left = 0;
      pay_sum    = '0;
      tags_due_q.delete();
      pending_o  = 0;
    end else begin
      // results first, so a request taken on the same edge never meets its own tag
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.out_byte, out_mon.in_frame, out_mon.frame_first, out_mon.frame_last};
        if (tags_due_q.size() == 0) begin
          report_tag("result with nothing due", seen, '0);
        end else begin
          due = tags_due_q.pop_front();
          if (seen !== due) report_tag("tag mismatch", seen, due);
        end
      end
      if (in_mon.valid && in_mon.ready) slide_window(in_mon.in_byte);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sfc_pkg::CfgStartValue: start_val = cfg_data_i;
          sfc_pkg::CfgEndValue:   end_val = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = tags_due_q.size();
    end
  end

  always @(posedge run_over_i) begin
    if (tags_due_q.size() != 0) begin
      report_tag($sformatf("%0d results never came, oldest", tags_due_q.size()), '0,
                 tags_due_q[0]);
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for sof_eof_frame_checker_core
// Streams well-formed frames, broken frames and noise through the core under
// several marker settings, with random idle bursts on both channels and one
// long output hold, while sfc_tag_checker predicts and compares the tags.
// ----------------------------------------------------------------------------
module tb;

  localparam int WatchLimit = 2000;
  localparam int HoldCycles = 300;
  localparam logic [sfc_pkg::CfgIdxW-1:0] CfgUnusedLo = sfc_pkg::CfgEndValue + 1'b1;

  typedef enum int {FillRandom, FillZero, FillOnes, FillStarts} fill_e;
  typedef enum int {FrmGood, FrmBadEnd, FrmBadSum} frame_kind_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we;
  logic [sfc_pkg::CfgIdxW-1:0] cfg_idx;
  logic [sfc_pkg::ByteW-1:0]   cfg_data;
  logic                        run_over;
  logic [sfc_pkg::ByteW-1:0]   cur_start;
  logic [sfc_pkg::ByteW-1:0]   cur_end;
  logic [sfc_pkg::ByteW-1:0]   same_marker;
  logic                        calm;
  logic                        hold_req;
  int                          bytes_sent;
  int                          idle_cnt;
  int                          fail_cnt;
  int                          pending;

  sfc_in_if  in_if ();
  sfc_out_if out_if ();

  sof_eof_frame_checker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  sfc_tag_checker u_tag_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .run_over_i (run_over),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // output side: short random stalls, or one long hold on request
  initial begin : sink_side
    out_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        out_if.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt == WatchLimit) begin
        $display("[sof_eof_frame_checker_core] ERROR");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [sfc_pkg::ByteW-1:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.in_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_e kind, input fill_e fill);
    logic [sfc_pkg::ByteW-1:0] fr [sfc_pkg::FrameLen];
    logic [sfc_pkg::SumW-1:0]  sum;
    logic [sfc_pkg::ByteW-1:0] flip;
    for (int k = 0; k < sfc_pkg::FrameLen; k++) begin
      case (fill)
        FillZero:   fr[k] = '0;
        FillOnes:   fr[k] = '1;
        // marker bytes inside a frame must never be taken as starts
        FillStarts: fr[k] = ($urandom_range(0, 3) == 0) ? cur_start :
                            sfc_pkg::ByteW'($urandom);
        default:    fr[k] = sfc_pkg::ByteW'($urandom);
      endcase
    end
    fr[0] = cur_start;
    sum = '0;
    for (int k = sfc_pkg::PayloadFirst; k < sfc_pkg::PayloadFirst + sfc_pkg::PayloadLen;
         k++) begin
      sum += sfc_pkg::SumW'(fr[k]);
    end
    fr[sfc_pkg::SumPos]     = sum[7:0];
    fr[sfc_pkg::SumPos + 1] = sum[15:8];
    fr[sfc_pkg::EndPos]     = cur_end;
    flip = sfc_pkg::ByteW'(1) << $urandom_range(0, sfc_pkg::ByteW - 1);
    case (kind)
      FrmBadEnd: fr[sfc_pkg::EndPos] ^= flip;
      FrmBadSum: fr[sfc_pkg::SumPos + $urandom_range(0, 1)] ^= flip;
      default: ;
    endcase
    for (int k = 0; k < sfc_pkg::FrameLen; k++) push_byte(fr[k]);
  endtask

  task automatic send_noise(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 5);
      push_byte(r == 0 ? cur_start : (r == 1 ? cur_end : sfc_pkg::ByteW'($urandom)));
    end
  endtask

  task automatic random_traffic(input int budget);
    int stop_at;
    int pick;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) send_frame(FrmGood, fill_e'($urandom_range(0, 3)));
      else if (pick == 5) send_frame(FrmBadEnd, fill_e'($urandom_range(0, 3)));
      else if (pick == 6) send_frame(FrmBadSum, fill_e'($urandom_range(0, 3)));
      else send_noise($urandom_range(1, 24));
    end
  endtask

  // stop requests, let every due result out, then allow for bytes still settling
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_markers(input logic [sfc_pkg::ByteW-1:0] sv,
                              input logic [sfc_pkg::ByteW-1:0] ev);
    cfg_we   <= 1'b1;
    cfg_idx  <= sfc_pkg::CfgStartValue;
    cfg_data <= sv;
    @(posedge clk_i);
    cfg_idx  <= sfc_pkg::CfgEndValue;
    cfg_data <= ev;
    @(posedge clk_i);
    // unused index, must leave both markers alone
    cfg_idx  <= CfgUnusedLo + sfc_pkg::CfgIdxW'($urandom_range(0, 1));
    cfg_data <= ~ev;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_start = sv;
    cur_end   = ev;
  endtask

  initial begin : stimulus
    in_if.valid   <= 1'b0;
    in_if.in_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= sfc_pkg::CfgStartValue;
    cfg_data      <= '0;
    run_over      <= 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    bytes_sent = 0;
    idle_cnt   = 0;
    cur_start  = sfc_pkg::StartValueRst;
    cur_end    = sfc_pkg::EndValueRst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed frames at the reset markers
    send_frame(FrmGood, FillOnes);
    send_frame(FrmBadEnd, FillStarts);

    hold_req = 1'b1;
    random_traffic(100);
    settle();

    load_markers('0, '1);
    random_traffic(80);
    settle();

    load_markers('1, '0);
    random_traffic(80);
    settle();

    same_marker = sfc_pkg::ByteW'($urandom);
    load_markers(same_marker, same_marker);
    calm = 1'b1;
    random_traffic(80);
    settle();

    run_over <= 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[sof_eof_frame_checker_core] OK");
    end else begin
      $display("[sof_eof_frame_checker_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sfc_pkg.sv
rtl/sfc_if.sv
rtl/sfc_cell.sv
rtl/sfc_sum.sv
rtl/sof_eof_frame_checker_core.sv
test/sfc_tag_checker.sv
test/tb.sv
